[design/periodic_gap_frame_dropper_defines.svh]
// Assertion macros used by the top-level design file.
`ifndef PERIODIC_GAP_FRAME_DROPPER_DEFINES_SVH
`define PERIODIC_GAP_FRAME_DROPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define PGFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pgfd assertion failed");
// Checked on every clock edge, reset included.
`define PGFD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pgfd assertion failed");
`else
`define PGFD_ASSERT(lbl, clk, rst_n, prop)
`define PGFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[design/pgfd_pkg.sv]
package pgfd_pkg;

    localparam int TRACK_ENTRIES  = 16;
    localparam int DATA_TYPE_CODE = 1;

    localparam logic [1:0] REG_TARGET_TERM    = 2'd0;
    localparam logic [1:0] REG_GAP_RADIX_BITS = 2'd1;
    localparam logic [1:0] REG_GAP_LENGTH     = 2'd2;
    localparam logic [1:0] REG_GAP_COUNT      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_JUDGE,
        S_EMIT
    } pgfd_state_t;

    // handed from cell to cell along the table
    typedef struct packed {
        logic hit;
        logic free_seen;
    } pgfd_chain_t;

    // broadcast to every cell
    typedef struct packed {
        logic        alloc_en;
        logic [30:0] alloc_offset;
        logic        upd_en;
        logic [31:0] upd_value;
    } pgfd_cell_ctrl_t;

endpackage

[design/pgfd_cell.sv]
module pgfd_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [63:0]              key,
    input  pgfd_pkg::pgfd_cell_ctrl_t ctrl,
    input  logic                     sel,
    input  pgfd_pkg::pgfd_chain_t    chain_in,
    output pgfd_pkg::pgfd_chain_t    chain_out,
    output logic                     hit,
    output logic                     claim,
    output logic [31:0]              track_offset
);

    logic        used_reg;
    logic        used_next;
    logic [63:0] key_reg;
    logic [31:0] track_reg;

    assign hit                 = used_reg && (key_reg == key);
    assign chain_out.hit       = chain_in.hit | hit;
    assign chain_out.free_seen = chain_in.free_seen | !used_reg;
    // used cells form a prefix, so the first free cell takes a new key
    assign claim               = ctrl.alloc_en && !used_reg && !chain_in.free_seen;
    assign track_offset        = track_reg;
    assign used_next           = used_reg | claim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            key_reg   <= key;
            track_reg <= {1'b0, ctrl.alloc_offset};
        end
        else if (ctrl.upd_en && sel)
        begin
            track_reg <= ctrl.upd_value;
        end
    end

endmodule

[design/periodic_gap_frame_dropper.sv]
// Periodic gap frame dropper: one drop flag per received frame header.
// Input channel (in_valid/in_ready) carries one header item; output channel
// (out_valid/out_ready) returns its drop flag, in order, one per item.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user writes
// it only while idle, and the block itself does not enforce this.
// After an item is accepted it passes through table lookup along the chain
// of tracking cells, gap judgment with the tracking update, then the result
// load. The block holds one item at a time and takes no new item until the
// last one's flag is loaded; a stalled output holds up that load.
// While out_ready is low the flag waits in the output register, the next
// item is still taken and waits at the end of its judgment.
// Reset clears the configuration registers to zero and empties the table
// at once through the per-cell used bits; no clearing pass is needed.
module periodic_gap_frame_dropper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        frame_type,
    input  logic signed [31:0] frame_term,
    input  logic [30:0]        frame_offset,
    input  logic signed [31:0] stream_number,
    input  logic signed [31:0] session_number,
    input  logic [15:0]        frame_length,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               drop
);

`include "periodic_gap_frame_dropper_defines.svh"

    localparam int N = pgfd_pkg::TRACK_ENTRIES;

    pgfd_pkg::pgfd_state_t state_reg, state_next;

    logic [31:0] target_term_reg;
    logic [4:0]  radix_bits_reg;
    logic [30:0] gap_length_reg;
    logic [15:0] gap_count_reg;

    logic [15:0] type_reg;
    logic [31:0] term_reg;
    logic [30:0] offset_reg;
    logic [63:0] key_reg;
    logic [15:0] length_reg;

    logic         qual_reg;
    logic         have_reg;
    logic [N-1:0] sel_reg;
    logic [31:0]  track_reg;
    logic         res_reg;
    logic         out_valid_reg;
    logic         drop_reg;

    logic accept, look_en, judge_en, emit_en;

    pgfd_pkg::pgfd_chain_t   chain [N+1];
    pgfd_pkg::pgfd_cell_ctrl_t ctrl;
    logic [N-1:0]  hit_vec;
    logic [N-1:0]  claim_vec;
    logic [31:0]   cell_track [N];
    logic [31:0]   track_mux;

    logic [46:0] count_shifted;
    logic [47:0] last_limit;
    logic        qual_now;

    logic [31:0] radix;
    logic [30:0] mask;
    logic [30:0] prev_gap;
    logic [31:0] prev_end;
    logic [32:0] next_gap;
    logic [33:0] next_end;
    logic [31:0] frame_end;
    logic        cond_boundary, cond_prev, cond_next, behind, res_next;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgfd_pkg::S_IDLE:  if (in_valid) state_next = pgfd_pkg::S_LOOK;
            pgfd_pkg::S_LOOK:  state_next = pgfd_pkg::S_JUDGE;
            pgfd_pkg::S_JUDGE: state_next = pgfd_pkg::S_EMIT;
            pgfd_pkg::S_EMIT:  if (!out_valid_reg || out_ready) state_next = pgfd_pkg::S_IDLE;
            default:           state_next = pgfd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        look_en  = 1'b0;
        judge_en = 1'b0;
        emit_en  = 1'b0;
        unique case (state_reg)
            pgfd_pkg::S_IDLE:  in_ready = 1'b1;
            pgfd_pkg::S_LOOK:  look_en  = 1'b1;
            pgfd_pkg::S_JUDGE: judge_en = 1'b1;
            pgfd_pkg::S_EMIT:  emit_en  = !out_valid_reg || out_ready;
            default:           in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pgfd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_term_reg <= '0;
            radix_bits_reg  <= '0;
            gap_length_reg  <= '0;
            gap_count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pgfd_pkg::REG_TARGET_TERM:    target_term_reg <= cfg_data;
                pgfd_pkg::REG_GAP_RADIX_BITS: radix_bits_reg  <= cfg_data[4:0];
                pgfd_pkg::REG_GAP_LENGTH:     gap_length_reg  <= cfg_data[30:0];
                pgfd_pkg::REG_GAP_COUNT:      gap_count_reg   <= cfg_data[15:0];
                default:                      target_term_reg <= target_term_reg;
            endcase
        end
    end

    // ---------------- capture ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= frame_type;
            term_reg   <= frame_term;
            offset_reg <= frame_offset;
            key_reg    <= {stream_number, session_number};
            length_reg <= frame_length;
        end
    end

    // ---------------- lookup ----------------
    assign count_shifted = {31'd0, gap_count_reg} << radix_bits_reg;
    assign last_limit    = {1'b0, count_shifted} + {17'd0, gap_length_reg};
    assign qual_now      = (type_reg == 16'(pgfd_pkg::DATA_TYPE_CODE))
                        && (term_reg == target_term_reg)
                        && ({17'd0, offset_reg} <= last_limit);

    assign chain[0] = '{hit: 1'b0, free_seen: 1'b0};

    assign ctrl.alloc_en     = look_en && qual_now && !chain[N].hit;
    assign ctrl.alloc_offset = offset_reg;
    assign ctrl.upd_en       = judge_en && res_next;
    assign ctrl.upd_value    = frame_end;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        pgfd_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .key          (key_reg),
            .ctrl         (ctrl),
            .sel          (sel_reg[i]),
            .chain_in     (chain[i]),
            .chain_out    (chain[i+1]),
            .hit          (hit_vec[i]),
            .claim        (claim_vec[i]),
            .track_offset (cell_track[i])
        );
    end

    always_comb
    begin
        track_mux = '0;
        for (int i = 0; i < N; i++)
        begin
            track_mux = track_mux | (cell_track[i] & {32{hit_vec[i]}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_en)
        begin
            qual_reg  <= qual_now;
            have_reg  <= chain[N].hit || chain[N].free_seen;
            sel_reg   <= hit_vec | claim_vec;
            track_reg <= chain[N].hit ? track_mux : {1'b0, offset_reg};
        end
    end

    // ---------------- judgment ----------------
    assign radix     = 32'd1 << radix_bits_reg;
    assign mask      = 31'(radix - 32'd1);
    assign prev_gap  = offset_reg & ~mask;
    assign prev_end  = {1'b0, prev_gap} + {1'b0, gap_length_reg};
    assign next_gap  = {2'b0, prev_gap} + {1'b0, radix};
    assign next_end  = {1'b0, next_gap} + {3'b0, gap_length_reg};
    assign frame_end = {1'b0, offset_reg} + {16'd0, length_reg};

    assign cond_boundary = (offset_reg != '0) && ((offset_reg & mask) == '0);
    assign cond_prev     = (prev_gap != '0) && ({1'b0, offset_reg} < prev_end);
    assign cond_next     = ({1'b0, frame_end} > next_gap)
                        && ({3'b0, offset_reg} < next_end);
    assign behind        = track_reg > {1'b0, offset_reg};
    assign res_next      = qual_reg && have_reg && !behind
                        && (cond_boundary || cond_prev || cond_next);

    always_ff @(posedge clk)
    begin
        if (judge_en)
        begin
            res_reg <= res_next;
        end
    end

    // ---------------- result ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            drop_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign drop      = drop_reg;

    `PGFD_ASSERT(a_accept_to_look, clk, rst_n, accept |=> (state_reg == pgfd_pkg::S_LOOK))
    `PGFD_ASSERT(a_sel_onehot, clk, rst_n, (state_reg == pgfd_pkg::S_JUDGE) |-> $onehot0(sel_reg))
    `PGFD_ASSERT(a_single_claim, clk, rst_n, $onehot0(claim_vec))
    `PGFD_ASSERT(a_drop_has_entry, clk, rst_n, (judge_en && res_next) |-> (have_reg && qual_reg))
    `PGFD_ASSERT_ALWAYS(a_emit_gated, clk, emit_en |-> (!out_valid_reg || out_ready))

endmodule

[bench/pgfd_drop_checker.sv]
module pgfd_drop_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [15:0]        frame_type,
    input  logic signed [31:0] frame_term,
    input  logic [30:0]        frame_offset,
    input  logic signed [31:0] stream_number,
    input  logic signed [31:0] session_number,
    input  logic [15:0]        frame_length,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               drop,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] target_term;
    logic [4:0]  gap_bits;
    logic [30:0] gap_len;
    logic [15:0] gap_count;

    logic        slot_used  [pgfd_pkg::TRACK_ENTRIES];
    logic [63:0] slot_key   [pgfd_pkg::TRACK_ENTRIES];
    logic [31:0] slot_track [pgfd_pkg::TRACK_ENTRIES];

    logic        drop_due [$];
    logic        due_flag;

    // Judges one frame header, claiming a free slot for a new key, and moves the tracking offset on a drop.
    function automatic logic judge_frame(
        input logic [15:0] ftype,
        input logic [31:0] fterm,
        input logic [30:0] foff,
        input logic [63:0] fkey,
        input logic [15:0] flen
    );
        logic [63:0] radix;
        logic [63:0] last_limit;
        logic [63:0] off;
        logic [63:0] frame_end;
        logic [63:0] prev_gap;
        logic [63:0] next_gap;
        logic        hit;
        int          slot;
        int          i;
        radix      = 64'd1 << gap_bits;
        last_limit = ({48'd0, gap_count} << gap_bits) + {33'd0, gap_len};
        off        = {33'd0, foff};
        if (ftype != 16'(pgfd_pkg::DATA_TYPE_CODE))
            return 1'b0;
        if (fterm != target_term)
            return 1'b0;
        if (off > last_limit)
            return 1'b0;
        slot = -1;
        for (i = 0; i < pgfd_pkg::TRACK_ENTRIES; i++)
        begin
            if (slot < 0 && slot_used[i] && slot_key[i] == fkey)
                slot = i;
        end
        if (slot < 0)
        begin
            for (i = 0; i < pgfd_pkg::TRACK_ENTRIES; i++)
            begin
                if (slot < 0 && !slot_used[i])
                begin
                    slot          = i;
                    slot_used[i]  = 1'b1;
                    slot_key[i]   = fkey;
                    slot_track[i] = {1'b0, foff};
                end
            end
            if (slot < 0)
                return 1'b0;
        end
        if ({32'd0, slot_track[slot]} > off)
            return 1'b0;
        frame_end = off + {48'd0, flen};
        hit       = 1'b0;
        if (off != 0 && (off & (radix - 64'd1)) == 0)
            hit = 1'b1;
        else
        begin
            prev_gap = off & ~(radix - 64'd1);
            if (prev_gap > 0 && off < prev_gap + {33'd0, gap_len})
                hit = 1'b1;
            else
            begin
                next_gap = ((off >> gap_bits) + 64'd1) << gap_bits;
                if (frame_end > next_gap && off < next_gap + {33'd0, gap_len})
                    hit = 1'b1;
            end
        end
        if (hit)
            slot_track[slot] = frame_end[31:0];
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_term = '0;
            gap_bits    = '0;
            gap_len     = '0;
            gap_count   = '0;
            for (int i = 0; i < pgfd_pkg::TRACK_ENTRIES; i++)
                slot_used[i] = 1'b0;
            drop_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drop_due.size() == 0)
                begin
                    $display("%0t: drop flag %0b with no item outstanding", $time, drop);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    due_flag = drop_due.pop_front();
                    if (drop !== due_flag)
                    begin
                        $display("%0t: drop mismatch, expected %0b actual %0b",
                                 $time, due_flag, drop);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    pgfd_pkg::REG_TARGET_TERM:    target_term = cfg_data;
                    pgfd_pkg::REG_GAP_RADIX_BITS: gap_bits    = cfg_data[4:0];
                    pgfd_pkg::REG_GAP_LENGTH:     gap_len     = cfg_data[30:0];
                    pgfd_pkg::REG_GAP_COUNT:      gap_count   = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                drop_due.push_back(judge_frame(frame_type, frame_term, frame_offset,
                                               {stream_number, session_number},
                                               frame_length));
            outstanding <= drop_due.size();
        end
    end

endmodule

[bench/tb_periodic_gap_frame_dropper.sv]
module tb_periodic_gap_frame_dropper;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          POOL        = 15;
    localparam longint      MAX_OFFSET  = 64'h7FFF_FFFF;
    localparam logic [15:0] DATA_TYPE   = 16'(pgfd_pkg::DATA_TYPE_CODE);

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [15:0]        frame_type;
    logic signed [31:0] frame_term;
    logic [30:0]        frame_offset;
    logic signed [31:0] stream_number;
    logic signed [31:0] session_number;
    logic [15:0]        frame_length;
    logic               out_valid;
    logic               out_ready;
    logic               drop;
    int                 mismatches;
    int                 outstanding;

    int          cycle_count = 0;
    bit          stall_on;
    logic [4:0]  cur_bits;
    logic [30:0] cur_len;
    logic [15:0] cur_count;
    logic [63:0] key_pool [POOL];
    longint      cursor   [POOL];

    periodic_gap_frame_dropper dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_type     (frame_type),
        .frame_term     (frame_term),
        .frame_offset   (frame_offset),
        .stream_number  (stream_number),
        .session_number (session_number),
        .frame_length   (frame_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drop           (drop)
    );

    pgfd_drop_checker drop_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_type     (frame_type),
        .frame_term     (frame_term),
        .frame_offset   (frame_offset),
        .stream_number  (stream_number),
        .session_number (session_number),
        .frame_length   (frame_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drop           (drop),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // receiver back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
        end
    endtask

    task automatic load_gaps(input logic [31:0] term, input logic [4:0] bits,
                             input logic [30:0] len, input logic [15:0] count);
        begin
            write_reg(pgfd_pkg::REG_TARGET_TERM, term);
            write_reg(pgfd_pkg::REG_GAP_RADIX_BITS, {27'd0, bits});
            write_reg(pgfd_pkg::REG_GAP_LENGTH, {1'b0, len});
            write_reg(pgfd_pkg::REG_GAP_COUNT, {16'd0, count});
            cfg_we    <= 1'b0;
            cur_bits  = bits;
            cur_len   = len;
            cur_count = count;
        end
    endtask

    task automatic send_frame(input logic [15:0] ftype, input logic [31:0] fterm,
                              input logic [30:0] foff, input logic [63:0] fkey,
                              input logic [15:0] flen);
        begin
            if (stall_on && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            in_valid       <= 1'b1;
            frame_type     <= ftype;
            frame_term     <= fterm;
            frame_offset   <= foff;
            stream_number  <= fkey[63:32];
            session_number <= fkey[31:0];
            frame_length   <= flen;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    // sender holds off until every drop flag is back
    task automatic settle();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (outstanding != 0);
            repeat (6) @(posedge clk);
        end
    endtask

    // offset a little before, inside or just after some gap
    function automatic longint near_gap_offset();
        longint base;
        longint pos;
        longint top_gap;
        top_gap = (MAX_OFFSET >> cur_bits) + 1;
        if (longint'(cur_count) < top_gap)
            top_gap = longint'(cur_count);
        base = longint'($urandom_range(0, int'(top_gap))) << cur_bits;
        pos  = base + longint'($urandom_range(0, cur_len + 80)) - 40;
        if (pos < 0)
            pos = 0;
        if (pos > MAX_OFFSET)
            pos = MAX_OFFSET;
        return pos;
    endfunction

    task automatic run_phase(input logic [31:0] term, input logic [4:0] bits,
                             input logic [30:0] len, input logic [15:0] count,
                             input int n_items, input bit quiet);
        longint      lim;
        longint      len_cap;
        longint      off;
        int          n;
        int          k;
        int          pick;
        logic [15:0] ftype;
        logic [15:0] flen;
        logic [31:0] fterm;
        logic [63:0] fkey;
        begin
            load_gaps(term, bits, len, count);
            lim     = (longint'(count) << bits) + longint'(len);
            len_cap = (bits >= 15) ? 65535 : (longint'(2) << bits);
            if (len_cap < 64)
                len_cap = 64;
            for (k = 0; k < POOL; k++)
                cursor[k] = near_gap_offset();
            for (n = 0; n < n_items; n++)
            begin
                if (n % 20 == 0)
                    stall_on = !quiet && ($urandom_range(0, 3) != 0);
                ftype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : DATA_TYPE;
                fterm = ($urandom_range(0, 9) == 0) ? $urandom : term;
                k     = $urandom_range(0, POOL - 1);
                fkey  = ($urandom_range(0, 14) == 0) ? {$urandom, $urandom} : key_pool[k];
                pick  = $urandom_range(0, 19);
                if (pick < 2)
                    flen = 16'($urandom);
                else if (pick < 4)
                    flen = pick[0] ? 16'hFFFF : 16'h0000;
                else
                    flen = 16'($urandom_range(0, int'(len_cap)));
                pick = $urandom_range(0, 19);
                if (pick < 9)
                begin
                    // in-order stream of frames for one key
                    if (cursor[k] > lim || cursor[k] > MAX_OFFSET)
                        cursor[k] = near_gap_offset();
                    off       = cursor[k];
                    cursor[k] = cursor[k] + flen;
                end
                else if (pick < 15)
                    off = near_gap_offset();
                else if (pick < 18)
                    off = longint'($urandom) % (((lim < MAX_OFFSET) ? lim : MAX_OFFSET) + 1);
                else
                    off = longint'($urandom) & MAX_OFFSET;
                send_frame(ftype, fterm, off[30:0], fkey, flen);
            end
            settle();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        frame_type     = '0;
        frame_term     = '0;
        frame_offset   = '0;
        stream_number  = '0;
        session_number = '0;
        frame_length   = '0;
        stall_on       = 1'b1;
        key_pool[0] = 64'h0000_0000_0000_0000;
        key_pool[1] = 64'h8000_0000_7FFF_FFFF;
        key_pool[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[3] = 64'h7FFF_FFFF_8000_0000;
        for (int i = 4; i < POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // radix 256, 16 byte gaps, last limit 1040
        load_gaps(32'd5, 5'd8, 31'd16, 16'd4);
        send_frame(16'h0000, 32'd5, 31'd256, key_pool[0], 16'd64);
        send_frame(16'hFFFF, 32'd5, 31'd256, key_pool[0], 16'd64);
        send_frame(DATA_TYPE, 32'd6, 31'd256, key_pool[0], 16'd64);
        send_frame(DATA_TYPE, 32'd5, 31'd1041, key_pool[0], 16'd0);
        send_frame(DATA_TYPE, 32'd5, 31'd0, key_pool[0], 16'd0);
        send_frame(DATA_TYPE, 32'd5, 31'd256, key_pool[0], 16'd40);
        send_frame(DATA_TYPE, 32'd5, 31'd100, key_pool[0], 16'd10);
        send_frame(DATA_TYPE, 32'd5, 31'd520, key_pool[0], 16'd8);
        send_frame(DATA_TYPE, 32'd5, 31'd700, key_pool[0], 16'd100);
        send_frame(DATA_TYPE, 32'd5, 31'd800, key_pool[0], 16'd10);
        send_frame(DATA_TYPE, 32'd5, 31'd1040, key_pool[1], 16'hFFFF);
        send_frame(DATA_TYPE, 32'd5, 31'h7FFF_FFFF, key_pool[2], 16'hFFFF);
        send_frame(DATA_TYPE, 32'd5, 31'd768, key_pool[3], 16'd0);
        send_frame(DATA_TYPE, 32'd5, 31'd1030, key_pool[2], 16'd1);
        settle();

        // radix wider than any offset, huge last limit
        load_gaps(32'h8000_0000, 5'd31, 31'd7, 16'hFFFF);
        send_frame(DATA_TYPE, 32'h8000_0000, 31'h7FFF_FFFF, key_pool[2], 16'hFFFF);
        send_frame(DATA_TYPE, 32'h8000_0000, 31'd5, key_pool[0], 16'd0);
        send_frame(DATA_TYPE, 32'h8000_0000, 31'h7FFF_FFF0, key_pool[1], 16'd10);
        settle();

        load_gaps(32'h7FFF_FFFF, 5'd30, 31'h7FFF_FFFF, 16'hFFFF);
        send_frame(DATA_TYPE, 32'h7FFF_FFFF, 31'h4000_0000, key_pool[3], 16'd0);
        send_frame(DATA_TYPE, 32'h7FFF_FFFF, 31'h4000_0001, key_pool[3], 16'd5);
        settle();

        run_phase(32'd0, 5'd0, 31'd0, 16'd0, 60, 1'b0);
        run_phase($urandom, 5'd6, 31'd8, 16'd20, 90, 1'b0);
        run_phase(32'h8000_0000, 5'd12, 31'd300, 16'd100, 90, 1'b0);
        run_phase(32'h7FFF_FFFF, 5'd30, 31'h7FFF_FFFF, 16'hFFFF, 80, 1'b0);
        run_phase(32'hFFFF_FFFF, 5'd31, 31'd1000, 16'd3, 60, 1'b0);
        run_phase($urandom, 5'd4, 31'd20, 16'd500, 90, 1'b0);
        run_phase($urandom, 5'd9, 31'd0, 16'hFFFF, 90, 1'b0);
        run_phase($urandom, 5'd7, 31'd40, 16'd50, 90, 1'b1);

        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[periodic_gap_frame_dropper.f]
+incdir+design
design/pgfd_pkg.sv
design/pgfd_cell.sv
design/periodic_gap_frame_dropper.sv
bench/pgfd_drop_checker.sv
bench/tb_periodic_gap_frame_dropper.sv
